/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the polygon collision block.
// No dependencies; take it in with a plain include of the file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define CPSAT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CPSAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/cpsat_pkg.sv */
// Package for the convex polygon collision block: widths, types, FSM encoding.
// No dependencies.
`default_nettype none

package cpsat_pkg;

   localparam int COORD_BITS        = 16;
   localparam int MAX_VERTICES_DFLT = 8;
   localparam int VERT_BITS         = 2 * COORD_BITS;   // {y, x}
   localparam int NORM_BITS         = COORD_BITS + 1;   // edge components
   localparam int PROD_BITS         = 2 * COORD_BITS + 1;
   localparam int SUM_BITS          = 2 * COORD_BITS + 2;

   typedef enum logic {
      POLY_A,
      POLY_B
   } poly_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EDGE_I,
      ST_EDGE_J,
      ST_NORMAL,
      ST_PROJ,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_COMPARE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     wr_a;          // store vertex into polygon A
      logic     wr_b;          // store vertex into polygon B
      poly_type rd_poly;       // store that the read address targets
      logic     latch_vi;      // capture edge start vertex
      logic     latch_normal;  // form edge normal from start and end vertex
      logic     proj_valid;    // a projection read is issued
      logic     proj_first;    // first vertex of its polygon on this axis
      logic     set_hit;
      logic     clr_hit;
   } cmd_type;

   typedef struct packed {
      logic separated;         // intervals strictly disjoint on current axis
   } status_type;

endpackage

`default_nettype wire

/* hdl/cpsat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on cpsat_pkg for parameter defaults.
`default_nettype none

module cpsat_ram
   import cpsat_pkg::*;
#(
   parameter int WIDTH = VERT_BITS,
   parameter int DEPTH = MAX_VERTICES_DFLT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/cpsat_ctrl.sv */
// Controller: vertex counts, drop flag, edge and projection loops, test FSM.
// Depends on cpsat_pkg.
`default_nettype none

module cpsat_ctrl
   import cpsat_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DFLT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            req_second_polygon,
   input  wire logic                            req_end_of_pair,
   output      logic                            busy,
   output      logic                            rsp_strobe,
   output      logic                            rsp_overflow,
   output      cmd_type                         cmd,
   output      logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
   output      logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
   input  wire status_type                      status
);

   localparam int ADDR_BITS = $clog2(MAX_VERTICES);
   localparam int CNT_BITS  = $clog2(MAX_VERTICES + 1);

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_a_ff, cnt_a_in;
   logic [CNT_BITS-1:0]    cnt_b_ff, cnt_b_in;
   logic                   drop_ff, drop_in;
   poly_type               edge_poly_ff, edge_poly_in;
   logic [ADDR_BITS-1:0]   edge_ff, edge_in;
   poly_type               proj_poly_ff, proj_poly_in;
   logic [ADDR_BITS-1:0]   proj_ff, proj_in;

   logic                   accept;
   logic                   a_full, b_full, a_empty, b_empty;
   logic [CNT_BITS-1:0]    edge_cnt, proj_cnt;
   logic                   edge_last, proj_last;
   logic [ADDR_BITS-1:0]   edge_next_idx;

   assign accept   = (state_ff == ST_IDLE) && start;
   assign a_full   = (cnt_a_ff == CNT_BITS'(MAX_VERTICES));
   assign b_full   = (cnt_b_ff == CNT_BITS'(MAX_VERTICES));
   assign a_empty  = (cnt_a_ff == '0);
   assign b_empty  = (cnt_b_ff == '0);
   assign edge_cnt = (edge_poly_ff == POLY_B) ? cnt_b_ff : cnt_a_ff;
   assign proj_cnt = (proj_poly_ff == POLY_B) ? cnt_b_ff : cnt_a_ff;
   assign edge_last = ((CNT_BITS'(edge_ff) + CNT_BITS'(1)) == edge_cnt);
   assign proj_last = ((CNT_BITS'(proj_ff) + CNT_BITS'(1)) == proj_cnt);
   assign edge_next_idx = edge_last ? '0 : edge_ff + ADDR_BITS'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_end_of_pair) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = (a_empty || b_empty) ? ST_DONE : ST_EDGE_I;
         end
         ST_EDGE_I: state_in = ST_EDGE_J;
         ST_EDGE_J: state_in = ST_NORMAL;
         ST_NORMAL: state_in = ST_PROJ;
         ST_PROJ: begin
            if (proj_poly_ff == POLY_B && proj_last) state_in = ST_DRAIN1;
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_COMPARE;
         ST_COMPARE: begin
            if (status.separated || (edge_last && edge_poly_ff == POLY_B)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_EDGE_I;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.rd_poly  = POLY_A;
      rd_addr      = '0;
      busy         = 1'b1;
      rsp_strobe   = 1'b0;
      wr_addr      = req_second_polygon ? cnt_b_ff[ADDR_BITS-1:0] : cnt_a_ff[ADDR_BITS-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.wr_a = accept && !req_second_polygon && !a_full;
            cmd.wr_b = accept && req_second_polygon && !b_full;
         end
         ST_CHECK: begin
            // exactly one empty polygon cannot collide; both empty: no axis
            if (a_empty ^ b_empty) cmd.clr_hit = 1'b1;
            else                   cmd.set_hit = 1'b1;
         end
         ST_EDGE_I: begin
            cmd.rd_poly = edge_poly_ff;
            rd_addr     = edge_ff;
         end
         ST_EDGE_J: begin
            cmd.rd_poly  = edge_poly_ff;
            rd_addr      = edge_next_idx;
            cmd.latch_vi = 1'b1;
         end
         ST_NORMAL: begin
            cmd.rd_poly      = edge_poly_ff;
            cmd.latch_normal = 1'b1;
         end
         ST_PROJ: begin
            cmd.rd_poly    = proj_poly_ff;
            rd_addr        = proj_ff;
            cmd.proj_valid = 1'b1;
            cmd.proj_first = (proj_ff == '0);
         end
         ST_DRAIN1, ST_DRAIN2: begin
         end
         ST_COMPARE: begin
            cmd.clr_hit = status.separated;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_overflow = drop_ff;

   // counts and loop indexes
   always_comb begin
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      drop_in      = drop_ff;
      edge_poly_in = edge_poly_ff;
      edge_in      = edge_ff;
      proj_poly_in = proj_poly_ff;
      proj_in      = proj_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_second_polygon) begin
                  if (b_full) drop_in = 1'b1;
                  else        cnt_b_in = cnt_b_ff + CNT_BITS'(1);
               end else begin
                  if (a_full) drop_in = 1'b1;
                  else        cnt_a_in = cnt_a_ff + CNT_BITS'(1);
               end
            end
         end
         ST_CHECK: begin
            edge_poly_in = POLY_A;
            edge_in      = '0;
         end
         ST_NORMAL: begin
            proj_poly_in = POLY_A;
            proj_in      = '0;
         end
         ST_PROJ: begin
            if (proj_last) begin
               proj_poly_in = POLY_B;
               proj_in      = '0;
            end else begin
               proj_in = proj_ff + ADDR_BITS'(1);
            end
         end
         ST_COMPARE: begin
            if (edge_last) begin
               edge_poly_in = POLY_B;
               edge_in      = '0;
            end else begin
               edge_in = edge_ff + ADDR_BITS'(1);
            end
         end
         ST_DONE: begin
            cnt_a_in = '0;
            cnt_b_in = '0;
            drop_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_poly_ff <= edge_poly_in;
      edge_ff      <= edge_in;
      proj_poly_ff <= proj_poly_in;
      proj_ff      <= proj_in;
   end

endmodule

`default_nettype wire

/* hdl/cpsat_dp.sv */
// Datapath: vertex RAMs, edge normal, projection pipeline, interval min/max.
// Depends on cpsat_pkg and cpsat_ram.
`default_nettype none

module cpsat_dp
   import cpsat_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DFLT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic signed [COORD_BITS-1:0]           req_vertex_x,
   input  wire logic signed [COORD_BITS-1:0]           req_vertex_y,
   input  wire cmd_type                                cmd,
   input  wire logic        [$clog2(MAX_VERTICES)-1:0] wr_addr,
   input  wire logic        [$clog2(MAX_VERTICES)-1:0] rd_addr,
   output      status_type                             status,
   output      logic                                   rsp_collide
);

   logic [VERT_BITS-1:0]          wr_data, rd_data_a, rd_data_b, vert;
   poly_type                      rd_poly_d1_ff;
   logic signed [COORD_BITS-1:0]  vx, vy;
   logic signed [COORD_BITS-1:0]  vix_ff, viy_ff;
   logic signed [NORM_BITS-1:0]   nx_ff, ny_ff;

   logic                          s1_valid_ff, s1_first_ff;
   poly_type                      s1_poly_ff;
   logic                          s2_valid_ff, s2_first_ff;
   poly_type                      s2_poly_ff;
   logic signed [PROD_BITS-1:0]   prod_x_ff, prod_y_ff;
   logic signed [SUM_BITS-1:0]    proj_sum;
   logic signed [SUM_BITS-1:0]    alo_ff, ahi_ff, blo_ff, bhi_ff;
   logic                          hit_ff;

   assign wr_data = {req_vertex_y, req_vertex_x};

   cpsat_ram #(
      .WIDTH (VERT_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (cmd.wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_a)
   );

   cpsat_ram #(
      .WIDTH (VERT_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (cmd.wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_b)
   );

   assign vert = (rd_poly_d1_ff == POLY_B) ? rd_data_b : rd_data_a;
   assign vx   = signed'(vert[COORD_BITS-1:0]);
   assign vy   = signed'(vert[VERT_BITS-1:COORD_BITS]);

   // axis = (-(yj - yi), xj - xi)
   always_ff @(posedge clock) begin
      rd_poly_d1_ff <= cmd.rd_poly;
      if (cmd.latch_vi) begin
         vix_ff <= vx;
         viy_ff <= vy;
      end
      if (cmd.latch_normal) begin
         nx_ff <= NORM_BITS'(viy_ff) - NORM_BITS'(vy);
         ny_ff <= NORM_BITS'(vx) - NORM_BITS'(vix_ff);
      end
   end

   // stage 1: RAM data -> products; stage 2: sum -> interval update
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.proj_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.proj_first;
      s1_poly_ff  <= cmd.rd_poly;
      s2_first_ff <= s1_first_ff;
      s2_poly_ff  <= s1_poly_ff;
      prod_x_ff   <= PROD_BITS'(nx_ff) * PROD_BITS'(vx);
      prod_y_ff   <= PROD_BITS'(ny_ff) * PROD_BITS'(vy);
   end

   assign proj_sum = SUM_BITS'(prod_x_ff) + SUM_BITS'(prod_y_ff);

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         if (s2_poly_ff == POLY_A) begin
            if (s2_first_ff || proj_sum < alo_ff) alo_ff <= proj_sum;
            if (s2_first_ff || proj_sum > ahi_ff) ahi_ff <= proj_sum;
         end else begin
            if (s2_first_ff || proj_sum < blo_ff) blo_ff <= proj_sum;
            if (s2_first_ff || proj_sum > bhi_ff) bhi_ff <= proj_sum;
         end
      end
   end

   assign status.separated = (ahi_ff < blo_ff) || (bhi_ff < alo_ff);

   always_ff @(posedge clock) begin
      if (cmd.set_hit)      hit_ff <= 1'b1;
      else if (cmd.clr_hit) hit_ff <= 1'b0;
   end

   assign rsp_collide = hit_ff;

endmodule

`default_nettype wire

/* hdl/convex_polygon_sat_collision.sv */
// Top level of the 2-D convex polygon collision block (separating axis test).
// Depends on cpsat_pkg, cpsat_ctrl, cpsat_dp (and cpsat_ram below it).
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+-------------------------
//   request  | req_second_polygon, req_vertex_x/y, req_end_of_pair | start & !busy
//   response | rsp_collide, rsp_overflow                     | rsp_strobe, one cycle
//
// A vertex transaction without the end marker leaves busy low.
// A vertex with the end marker starts the test and raises busy. For every edge
// walked (at most nA + nB), the single projection datapath reads one stored vertex per
// cycle from the polygon RAMs; the walk stops at the first separating axis.
// rsp_strobe marks the last busy cycle; results cannot be stalled.
// Reset (synchronous, active high) empties both polygon stores and the drop flag.
`default_nettype none

module convex_polygon_sat_collision
   import cpsat_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DFLT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output      logic                         busy,
   input  wire logic                         req_second_polygon,
   input  wire logic signed [COORD_BITS-1:0] req_vertex_x,
   input  wire logic signed [COORD_BITS-1:0] req_vertex_y,
   input  wire logic                         req_end_of_pair,
   output      logic                         rsp_strobe,
   output      logic                         rsp_collide,
   output      logic                         rsp_overflow
);

   localparam int ADDR_BITS = $clog2(MAX_VERTICES);

   cmd_type              cmd;
   status_type           status;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [ADDR_BITS-1:0] rd_addr;

   // sequencing: counts, loops over edges and vertices, result strobe
   cpsat_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_second_polygon (req_second_polygon),
      .req_end_of_pair    (req_end_of_pair),
      .busy               (busy),
      .rsp_strobe         (rsp_strobe),
      .rsp_overflow       (rsp_overflow),
      .cmd                (cmd),
      .wr_addr            (wr_addr),
      .rd_addr            (rd_addr),
      .status             (status)
   );

   // storage and arithmetic: normals, dot products, intervals, verdict
   cpsat_dp #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_vertex_x (req_vertex_x),
      .req_vertex_y (req_vertex_y),
      .cmd          (cmd),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .status       (status),
      .rsp_collide  (rsp_collide)
   );

endmodule

`default_nettype wire

/* hdl/cpsat_checker.sv */
// Port-level checker for the polygon collision block, bound to the top level.
// Depends on assert_macros.svh and convex_polygon_sat_collision.
`default_nettype none
`include "assert_macros.svh"

module cpsat_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_end_of_pair,
   input wire logic rsp_strobe
);

   logic xfer;

   // request transaction taken at this edge
   assign xfer = start && !busy;

   `CPSAT_ASSERT(a_strobe_busy, clock, reset, rsp_strobe |-> busy, "result outside a test")
   `CPSAT_ASSERT(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe, "result repeated")
   `CPSAT_ASSERT(a_load_free, clock, reset, (xfer && !req_end_of_pair) |=> !busy, "load stalled")
   `CPSAT_ASSERT(a_end_busy, clock, reset, (xfer && req_end_of_pair) |=> busy, "test not started")

endmodule

bind convex_polygon_sat_collision cpsat_checker u_cpsat_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_end_of_pair (req_end_of_pair),
   .rsp_strobe      (rsp_strobe)
);

`default_nettype wire
